### rtl/mqsb_pkg.sv
package mqsb_pkg;

	// fixed field widths of the item channels
	localparam int DATA_W = 32;
	localparam int QIDX_W = 2;

	// defaults for the top-level parameters
	localparam int CAPACITY_DEF    = 16;
	localparam int QUEUE_COUNT_DEF = 4;

	typedef enum logic {
		CMD_ENQ = 1'b0,
		CMD_DEQ = 1'b1
	} mqsb_cmd_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_OVERFLOW = 2'd1,
		ST_EMPTY    = 2'd2
	} mqsb_status_t;

	// per-item result of the list manager, consumed by the data store
	typedef struct packed {
		logic         wr;     // enqueue accepted: write data at slot
		logic         rd;     // dequeue accepted: read data at slot
		mqsb_status_t status;
	} mqsb_op_t;

endpackage

### rtl/mqsb_if.sv
interface mqsb_req_if;
	logic                                valid;
	logic                                ready;
	mqsb_pkg::mqsb_cmd_t                 command;
	logic [mqsb_pkg::QIDX_W-1:0]         queue_index;
	logic signed [mqsb_pkg::DATA_W-1:0]  data_in;

	modport source (output valid, command, queue_index, data_in, input ready);
	modport sink   (input valid, command, queue_index, data_in, output ready);
endinterface

interface mqsb_rsp_if;
	logic                                valid;
	logic                                ready;
	mqsb_pkg::mqsb_status_t              status;
	logic signed [mqsb_pkg::DATA_W-1:0]  data_out;

	modport source (output valid, status, data_out, input ready);
	modport sink   (input valid, status, data_out, output ready);
endinterface

### rtl/multi_queue_shared_buffer_unit.sv
// Several FIFO queues sharing one slot buffer, kept as linked lists with a
// linked free list.
// req channel: command (enqueue/dequeue), queue_index, data_in.
// rsp channel: status (ok / overflow / empty) and data_out; data_out is the
//   dequeued value, zero on enqueue and on any error.
// Exactly one rsp item per req item, in order.
// Throughput: one item per cycle while rsp is not held. Each command is handled
//   against the list state; the link memory's registered read is bypassed
//   into the free-list and queue-head pointers the next cycle.
// Path: an accepted req item passes the input register, then the result
//   register together with the registered data-memory read, before rsp valid.
// Stall: while rsp is held the result register holds and one more req item
//   is taken into the input register; req.ready then drops.
// Reset: all queues empty, free list is slots 0..CAPACITY-1 in order. No
//   clearing pass: never-allocated slots are tracked by a fill count.
// Queue indexes at or above QUEUE_COUNT report overflow on enqueue and
//   empty on dequeue.
module multi_queue_shared_buffer_unit #(
	parameter int CAPACITY    = mqsb_pkg::CAPACITY_DEF,
	parameter int QUEUE_COUNT = mqsb_pkg::QUEUE_COUNT_DEF,
	localparam int PW = $clog2(CAPACITY + 1)
) (
	input logic        clk,
	input logic        arst_n,
	mqsb_req_if.sink   req,
	mqsb_rsp_if.source rsp
);
	import mqsb_pkg::*;

	// input register
	logic                      valid_s1;
	mqsb_cmd_t                 command_s1;
	logic [QIDX_W-1:0]         queue_index_s1;
	logic signed [DATA_W-1:0]  data_in_s1;

	// result register (data_out is registered inside the store)
	logic                      valid_s2;
	mqsb_status_t              status_s2;

	logic                      adv;   // result register may load
	logic                      step;  // item in s1 is processed this cycle
	mqsb_op_t                  op;
	logic [PW-1:0]             slot;
	logic [PW-1:0]             used_q; // occupied slots, for checking only

	assign adv       = !valid_s2 || rsp.ready;
	assign step      = valid_s1 && adv;
	assign req.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			used_q   <= '0;
		end else begin
			if (req.ready) begin
				valid_s1 <= req.valid;
			end
			if (adv) begin
				valid_s2 <= valid_s1;
			end
			if (op.wr) begin
				used_q <= used_q + PW'(1);
			end else if (op.rd) begin
				used_q <= used_q - PW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			command_s1     <= req.command;
			queue_index_s1 <= req.queue_index;
			data_in_s1     <= req.data_in;
		end
		if (adv) begin
			status_s2 <= op.status;
		end
	end

	mqsb_list #(
		.CAPACITY    (CAPACITY),
		.QUEUE_COUNT (QUEUE_COUNT)
	) u_list (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.command     (command_s1),
		.queue_index (queue_index_s1),
		.op          (op),
		.slot        (slot)
	);

	mqsb_store #(
		.CAPACITY (CAPACITY)
	) u_store (
		.clk      (clk),
		.adv      (adv),
		.op       (op),
		.slot     (slot),
		.data_in  (data_in_s1),
		.data_out (rsp.data_out)
	);

	assign rsp.valid  = valid_s2;
	assign rsp.status = status_s2;

	// an accepted enqueue always finds a slot that is not in use
	a_enq_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		op.wr |-> (used_q < PW'(CAPACITY)))
		else $error("enqueue granted with buffer full");

	// overflow on a valid queue only when every slot is occupied
	a_overflow_full: assert property (@(posedge clk) disable iff (!arst_n)
		(step && (op.status == ST_OVERFLOW) && (int'(queue_index_s1) < QUEUE_COUNT))
		|-> (used_q == PW'(CAPACITY)))
		else $error("overflow reported with free slots left");

	// a processed item shows up as a result next cycle
	a_step_result: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> rsp.valid)
		else $error("processed item produced no result");

	// nonzero data only comes with a successful dequeue
	a_data_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && (rsp.data_out != '0)) |-> (rsp.status == ST_OK))
		else $error("data returned with error status");

endmodule

### rtl/mqsb_list.sv
module mqsb_list #(
	parameter int CAPACITY    = mqsb_pkg::CAPACITY_DEF,
	parameter int QUEUE_COUNT = mqsb_pkg::QUEUE_COUNT_DEF,
	localparam int PW = $clog2(CAPACITY + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step,
	input  mqsb_pkg::mqsb_cmd_t           command,
	input  logic [mqsb_pkg::QIDX_W-1:0]   queue_index,
	output mqsb_pkg::mqsb_op_t            op,
	output logic [PW-1:0]                 slot
);
	import mqsb_pkg::*;

	// only 2**QIDX_W queues are reachable through the index field
	localparam int QN = (QUEUE_COUNT < (2 ** QIDX_W)) ? QUEUE_COUNT : (2 ** QIDX_W);
	localparam int QW = (QN > 1) ? $clog2(QN) : 1;
	localparam int AW = $clog2(CAPACITY);
	localparam logic [PW-1:0] NONE = PW'(CAPACITY);

	logic [PW-1:0] head_q  [QN];
	logic [PW-1:0] tail_q  [QN];
	logic [PW-1:0] hnext_q [QN];  // link of each queue head
	logic [PW-1:0] free_head_q;
	logic [PW-1:0] free_next_q;   // link of free head
	logic [PW-1:0] fill_q;        // slots below this were allocated at least once
	logic          fpend_q;       // free_next arrives from link read this cycle
	logic          hpend_q;       // hnext of hsel_q arrives from link read
	logic [QW-1:0] hsel_q;
	logic          rd_fresh_q;
	logic [PW-1:0] rd_addr_q;
	logic [PW-1:0] link_rd_q;
	logic [PW-1:0] link_mem [CAPACITY];

	logic [QW-1:0] qi;
	logic          q_ok;
	logic          is_deq;
	logic [PW-1:0] link_val;
	logic [PW-1:0] fn_eff;
	logic [PW-1:0] hn_eff;
	logic [PW-1:0] head;
	logic [PW-1:0] tail;
	logic [PW-1:0] fh;
	logic          enq_ok;
	logic          deq_ok;
	logic          q_empty;
	logic          deq_last;
	logic [PW-1:0] fill_nx;
	logic          rd_en;
	logic [PW-1:0] rd_addr;
	logic          wr_en;
	logic [PW-1:0] wr_addr;

	assign qi     = queue_index[QW-1:0];
	assign q_ok   = (int'(queue_index) < QUEUE_COUNT);
	assign is_deq = (command == CMD_DEQ);

	// a never-allocated slot links to its successor
	assign link_val = rd_fresh_q ? (rd_addr_q + PW'(1)) : link_rd_q;
	assign fn_eff   = fpend_q ? link_val : free_next_q;
	assign hn_eff   = (hpend_q && (hsel_q == qi)) ? link_val : hnext_q[qi];

	assign head     = head_q[qi];
	assign tail     = tail_q[qi];
	assign fh       = free_head_q;
	assign enq_ok   = !is_deq && q_ok && (fh < NONE);
	assign deq_ok   = is_deq && q_ok && (head < NONE);
	assign q_empty  = !(head < NONE) || !(tail < NONE);
	assign deq_last = (head == tail);

	assign fill_nx = (step && enq_ok && (fh >= fill_q)) ? (fh + PW'(1)) : fill_q;

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = fn_eff;
		wr_en   = 1'b0;
		wr_addr = head;
		if (step && enq_ok) begin
			rd_en   = (fn_eff < NONE);
			wr_en   = !q_empty;
			wr_addr = tail;
		end
		if (step && deq_ok) begin
			rd_en   = !deq_last;
			rd_addr = hn_eff;
			wr_en   = 1'b1;
			wr_addr = head;
		end
	end

	always_comb begin
		op.wr     = step && enq_ok;
		op.rd     = step && deq_ok;
		op.status = is_deq ? (deq_ok ? ST_OK : ST_EMPTY) : (enq_ok ? ST_OK : ST_OVERFLOW);
		slot      = is_deq ? head : fh;
	end

	// link memory: one write, one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			link_mem[wr_addr[AW-1:0]] <= fh;
		end
		if (rd_en) begin
			link_rd_q <= link_mem[rd_addr[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < QN; i++) begin
				head_q[i]  <= NONE;
				tail_q[i]  <= NONE;
				hnext_q[i] <= NONE;
			end
			free_head_q <= '0;
			free_next_q <= PW'(1);
			fill_q      <= '0;
			fpend_q     <= 1'b0;
			hpend_q     <= 1'b0;
			hsel_q      <= '0;
			rd_fresh_q  <= 1'b0;
			rd_addr_q   <= '0;
		end else begin
			// absorb last cycle's link read; item updates below take priority
			if (fpend_q) begin
				free_next_q <= link_val;
			end
			if (hpend_q) begin
				hnext_q[hsel_q] <= link_val;
			end
			fpend_q <= 1'b0;
			hpend_q <= 1'b0;
			fill_q  <= fill_nx;
			if (rd_en) begin
				rd_fresh_q <= (rd_addr >= fill_nx);
				rd_addr_q  <= rd_addr;
			end
			if (step && enq_ok) begin
				free_head_q <= fn_eff;
				fpend_q     <= (fn_eff < NONE);
				if (q_empty) begin
					head_q[qi] <= fh;
				end else if (tail == head) begin
					hnext_q[qi] <= fh;
				end
				tail_q[qi] <= fh;
			end
			if (step && deq_ok) begin
				free_head_q <= head;
				free_next_q <= fh;
				if (deq_last) begin
					head_q[qi] <= NONE;
					tail_q[qi] <= NONE;
				end else begin
					head_q[qi] <= hn_eff;
					hpend_q    <= 1'b1;
					hsel_q     <= qi;
				end
			end
		end
	end

endmodule

### rtl/mqsb_store.sv
module mqsb_store #(
	parameter int CAPACITY = mqsb_pkg::CAPACITY_DEF,
	localparam int PW = $clog2(CAPACITY + 1)
) (
	input  logic                               clk,
	input  logic                               adv,
	input  mqsb_pkg::mqsb_op_t                 op,
	input  logic [PW-1:0]                      slot,
	input  logic signed [mqsb_pkg::DATA_W-1:0] data_in,
	output logic signed [mqsb_pkg::DATA_W-1:0] data_out
);
	import mqsb_pkg::*;

	localparam int AW = $clog2(CAPACITY);

	logic signed [DATA_W-1:0] mem [CAPACITY];
	logic signed [DATA_W-1:0] rd_q;
	logic                     zero_q;

	always_ff @(posedge clk) begin
		if (op.wr) begin
			mem[slot[AW-1:0]] <= data_in;
		end
		if (adv) begin
			rd_q   <= mem[slot[AW-1:0]];
			zero_q <= !op.rd;
		end
	end

	// enqueues and errors return zero
	assign data_out = zero_q ? '0 : rd_q;

endmodule

### dv/multi_queue_shared_buffer_unit_tb.sv
module multi_queue_shared_buffer_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mqsb_pkg::*;

	// block configuration under test (package defaults)
	localparam int CAP   = CAPACITY_DEF;
	localparam int QN    = QUEUE_COUNT_DEF;
	localparam int PW    = $clog2(CAP + 1);
	localparam int NONE  = CAP;         // "no slot" marker, as in the block
	localparam int RANDOM_ITEMS = 700;

	typedef logic [PW-1:0] slot_t;
	typedef logic signed [DATA_W-1:0] word_t;

	typedef struct packed {
		mqsb_status_t status;
		word_t        data;
	} reply_t;

	// Tracks the linked-list state of the shared buffer and keeps the
	// replies owed by the block, oldest first.
	class shared_buffer_tracker;
		slot_t  head_slot[QN];
		slot_t  tail_slot[QN];
		slot_t  next_slot[CAP];
		slot_t  free_slot;
		word_t  slot_value[CAP];
		reply_t replies_due[$];
		int     errors;
		int     n_enq, n_full, n_deq, n_empty;

		function new();
			for (int i = 0; i < QN; i++) begin
				head_slot[i] = slot_t'(NONE);
				tail_slot[i] = slot_t'(NONE);
			end
			for (int i = 0; i < CAP; i++) begin
				next_slot[i]  = slot_t'(i + 1);
				slot_value[i] = '0;
			end
			next_slot[CAP-1] = slot_t'(NONE);
			free_slot = '0;
		endfunction

		function bit live(slot_t s);
			return int'(s) < CAP;
		endfunction

		function int pending();
			return replies_due.size();
		endfunction

		function void note_command(mqsb_cmd_t cmd, logic [QIDX_W-1:0] qi, word_t word);
			reply_t r;
			slot_t  s;
			slot_t  nx;
			r.status = ST_OK;
			r.data   = '0;
			if (cmd == CMD_ENQ) begin
				if (int'(qi) >= QN || !live(free_slot)) begin
					r.status = ST_OVERFLOW;
					n_full++;
				end else begin
					s = free_slot;
					free_slot = next_slot[s];
					if (!live(head_slot[qi]) || !live(tail_slot[qi]))
						head_slot[qi] = s;
					else
						next_slot[tail_slot[qi]] = s;
					next_slot[s]  = slot_t'(NONE);
					tail_slot[qi] = s;
					slot_value[s] = word;
					n_enq++;
				end
			end else begin
				if (int'(qi) >= QN || !live(head_slot[qi])) begin
					r.status = ST_EMPTY;
					n_empty++;
				end else begin
					s  = head_slot[qi];
					nx = next_slot[s];
					if (!live(nx)) begin
						head_slot[qi] = slot_t'(NONE);
						tail_slot[qi] = slot_t'(NONE);
					end else begin
						head_slot[qi] = nx;
					end
					next_slot[s] = free_slot;
					free_slot    = s;
					r.data       = slot_value[s];
					n_deq++;
				end
			end
			replies_due.push_back(r);
		endfunction

		function void check_reply(mqsb_status_t st, word_t d);
			reply_t r;
			if (replies_due.size() == 0) begin
				$error("reply with no command pending: status %0d data_out %0d", st, d);
				errors++;
				return;
			end
			r = replies_due.pop_front();
			if (st !== r.status) begin
				$error("status: expected %0d, got %0d", r.status, st);
				errors++;
			end
			if (d !== r.data) begin
				$error("data_out: expected %0d, got %0d", r.data, d);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	mqsb_req_if req_ch ();
	mqsb_rsp_if rsp_ch ();

	multi_queue_shared_buffer_unit #(
		.CAPACITY    (CAP),
		.QUEUE_COUNT (QN)
	) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	shared_buffer_tracker tracker = new();

	// sender burst bookkeeping
	int burst_left = 1;
	// free-running count that picks the receiver's stall mode
	logic [7:0] ready_beat = '0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Receiver stall pattern: four modes picked by the top bits of a free-running
	// count - always ready, mostly ready, coin flip, and a periodic stall window.
	always @(posedge clk) begin
		ready_beat <= ready_beat + 8'd1;
		case (ready_beat[7:6])
			2'd0: begin
				rsp_ch.ready <= 1'b1;
			end
			2'd1: begin
				rsp_ch.ready <= ($urandom_range(0, 3) != 0);
			end
			2'd2: begin
				rsp_ch.ready <= ($urandom_range(0, 1) != 0);
			end
			default: begin
				rsp_ch.ready <= (ready_beat[4:0] >= 5'd10);
			end
		endcase
	end

	// Monitors: both handshakes are sampled at the edge, before any
	// nonblocking update of that edge lands.
	always @(posedge clk) begin
		if (arst_n && req_ch.valid && req_ch.ready)
			tracker.note_command(req_ch.command, req_ch.queue_index, req_ch.data_in);
		if (arst_n && rsp_ch.valid && rsp_ch.ready)
			tracker.check_reply(rsp_ch.status, rsp_ch.data_out);
	end

	// Present one item and hold it until the block takes it.
	task automatic send_item(mqsb_cmd_t cmd, logic [QIDX_W-1:0] qi, word_t word);
		req_ch.valid       <= 1'b1;
		req_ch.command     <= cmd;
		req_ch.queue_index <= qi;
		req_ch.data_in     <= word;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	// Send with bursty pacing: at the end of each burst drop valid for a
	// random gap; a zero gap keeps valid high, so long bursts run unbroken.
	task automatic issue(mqsb_cmd_t cmd, logic [QIDX_W-1:0] qi, word_t word);
		int gap;
		send_item(cmd, qi, word);
		burst_left--;
		if (burst_left <= 0) begin
			gap = $urandom_range(0, 5);
			if (gap > 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
			                                         : $urandom_range(1, 12);
		end
	endtask

	// Hold off the sender until every owed reply has come back. The first
	// edge lets the monitor record an item accepted at the current edge.
	task automatic drain();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (tracker.pending() != 0) @(posedge clk);
	endtask

	// Data pattern: mostly random, with the sign and zero corners mixed in.
	function automatic word_t pick_word();
		case ($urandom_range(0, 9))
			0: return word_t'(32'h8000_0000);
			1: return word_t'(32'h7fff_ffff);
			2: return '0;
			3: return '1;
			default: return word_t'($urandom);
		endcase
	endfunction

	initial begin
		int enq_pct;
		int phase_len;
		int focus_q;
		logic [QIDX_W-1:0] qi;

		arst_n             = 1'b0;
		req_ch.valid       = 1'b0;
		req_ch.command     = CMD_ENQ;
		req_ch.queue_index = '0;
		req_ch.data_in     = '0;
		rsp_ch.ready       = 1'b0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed ---
		// dequeue from an empty queue straight out of reset
		issue(CMD_DEQ, 2'd3, word_t'(32'h7fff_ffff));
		// data corners into queue 0
		issue(CMD_ENQ, 2'd0, word_t'(32'h8000_0000));
		issue(CMD_ENQ, 2'd0, word_t'(32'h7fff_ffff));
		issue(CMD_ENQ, 2'd0, '0);
		issue(CMD_ENQ, 2'd0, '1);
		// fill the rest of the buffer across queues 1..3
		for (int i = 0; i < CAP - 4; i++)
			issue(CMD_ENQ, QIDX_W'(1 + i % 3), word_t'(32'h5a5a_0000 + i));
		// no free slot left: overflow
		issue(CMD_ENQ, 2'd2, word_t'(32'h1234_5678));
		// drain queue 0 to empty, then one more dequeue hits an empty queue
		repeat (4) issue(CMD_DEQ, 2'd0, '0);
		issue(CMD_DEQ, 2'd0, '1);
		// reuse a slot that came back through the free list
		issue(CMD_ENQ, 2'd0, word_t'(32'hcafe_f00d));
		drain();

		// --- random ---
		// Phases with their own enqueue bias drive the buffer toward full or
		// empty; some phases aim all traffic at one queue.
		for (int n = 0; n < RANDOM_ITEMS; ) begin
			case ($urandom_range(0, 4))
				0: enq_pct = 10;
				1: enq_pct = 30;
				2: enq_pct = 50;
				3: enq_pct = 70;
				default: enq_pct = 90;
			endcase
			focus_q   = ($urandom_range(0, 1) == 0) ? int'($urandom_range(0, QN - 1)) : -1;
			phase_len = $urandom_range(20, 80);
			for (int k = 0; k < phase_len && n < RANDOM_ITEMS; k++, n++) begin
				qi = (focus_q >= 0) ? QIDX_W'(focus_q) : QIDX_W'($urandom_range(0, 3));
				if ($urandom_range(1, 100) <= enq_pct)
					issue(CMD_ENQ, qi, pick_word());
				else
					issue(CMD_DEQ, qi, pick_word());
				if (n == RANDOM_ITEMS / 2)
					drain();
			end
		end

		drain();
		repeat (8) @(posedge clk);

		$display("Ran %0d accepted enqueues and %0d overflows,", tracker.n_enq, tracker.n_full);
		$display("%0d dequeues with data and %0d from empty queues.",
		         tracker.n_deq, tracker.n_empty);
		if (tracker.errors == 0 && tracker.pending() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	// watchdog: far beyond the slowest legal run
	initial begin
		#5_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule
